FILE: rtl/aat_pkg.sv
// Active alarm table package: request, response and table entry types,
// status codes and sequencer states. No dependencies.
package aat_pkg;

   localparam logic [2:0] ST_ADDED     = 3'd0;
   localparam logic [2:0] ST_UPDATED   = 3'd1;
   localparam logic [2:0] ST_REMOVED   = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_INVALID   = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;
   localparam logic [2:0] ST_READ_OK   = 3'd6;
   localparam logic [2:0] ST_BAD_INDEX = 3'd7;

   localparam logic [15:0] MIN_CODE = 16'd1;
   localparam logic [15:0] MAX_CODE = 16'd7;

   typedef struct packed {
      logic        action;
      logic [15:0] event_code;
      logic [7:0]  event_level;
      logic        active;
      logic [7:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] entry_count;
      logic [2:0] highest_code;
      logic [2:0] entry_code;
      logic [7:0] entry_level;
   } rsp_type;

   typedef struct packed {
      logic [2:0] code;
      logic [7:0] level;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_EXEC,
      S_MOVE,
      S_TOP
   } state_type;

endpackage

FILE: rtl/active_alarm_table.sv
// Active alarm table top level: entry memory, search/update sequencer and
// highest-level scan. Depends on aat_pkg.
// Sequence, accept to response strobe: a read or invalid item runs the S_TOP scan
// only; a report runs S_FIND, S_EXEC, S_MOVE (removal only), then S_TOP.
// One item at a time, next transfer taken in the strobe cycle; no response stall.
// Synchronous reset empties the table (count to zero); memory is not cleared.
module active_alarm_table
   import aat_pkg::*;
#(
   parameter int TABLE_DEPTH = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   logic             mem_re, mem_we;
   logic [IDX_W-1:0] mem_raddr, mem_waddr;
   entry_type        mem_wdata;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [2:0]       status_ff, status_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] last_idx;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             dv_ff, dv_in;
   logic [IDX_W-1:0] didx_ff, didx_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   entry_type        best_ff, best_in;
   entry_type        ent_ff, ent_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   assign last_idx = count_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff    <= req_in;
      status_ff <= status_in;
      scan_ff   <= scan_in;
      didx_ff   <= didx_in;
      found_ff  <= found_in;
      pos_ff    <= pos_in;
      best_ff   <= best_in;
      ent_ff    <= ent_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      dv_in        = 1'b0;
      didx_in      = scan_ff[IDX_W-1:0];
      found_in     = found_ff;
      pos_in       = pos_ff;
      best_in      = best_ff;
      ent_in       = ent_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_re       = 1'b0;
      mem_raddr    = scan_ff[IDX_W-1:0];
      mem_we       = 1'b0;
      mem_waddr    = pos_ff;
      mem_wdata    = rd_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               scan_in  = '0;
               found_in = 1'b0;
               ent_in   = '0;
               if (req_data.action) begin
                  status_in = (req_data.read_index < 8'(count_ff)) ? ST_READ_OK
                                                                   : ST_BAD_INDEX;
                  state_in  = S_TOP;
               end else if (req_data.event_code < MIN_CODE ||
                            req_data.event_code > MAX_CODE ||
                            req_data.event_level == 8'd0) begin
                  status_in = ST_INVALID;
                  state_in  = S_TOP;
               end else begin
                  state_in = S_FIND;
               end
            end
         end
         S_FIND: begin
            if (scan_ff < count_ff) begin
               mem_re  = 1'b1;
               dv_in   = 1'b1;
               scan_in = scan_ff + 1'b1;
            end
            if (dv_ff && !found_ff &&
                rd_data_ff.code == req_ff.event_code[2:0]) begin
               found_in = 1'b1;
               pos_in   = didx_ff;
            end
            if (scan_ff == count_ff && !dv_ff) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            scan_in  = '0;
            state_in = S_TOP;
            if (req_ff.active) begin
               if (found_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = pos_ff;
                  mem_wdata = '{code: req_ff.event_code[2:0],
                                level: req_ff.event_level};
                  status_in = ST_UPDATED;
               end else if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                  status_in = ST_FULL;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = count_ff[IDX_W-1:0];
                  mem_wdata = '{code: req_ff.event_code[2:0],
                                level: req_ff.event_level};
                  count_in  = count_ff + 1'b1;
                  status_in = ST_ADDED;
               end
            end else if (found_ff) begin
               mem_re    = 1'b1;
               mem_raddr = last_idx[IDX_W-1:0];
               status_in = ST_REMOVED;
               state_in  = S_MOVE;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         S_MOVE: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = rd_data_ff;
            count_in  = count_ff - 1'b1;
            scan_in   = '0;
            state_in  = S_TOP;
         end
         S_TOP: begin
            if (scan_ff < count_ff) begin
               mem_re  = 1'b1;
               dv_in   = 1'b1;
               scan_in = scan_ff + 1'b1;
            end
            if (dv_ff) begin
               if (didx_ff == '0 || rd_data_ff.level > best_ff.level) begin
                  best_in = rd_data_ff;
               end
               if (req_ff.action && 8'(didx_ff) == req_ff.read_index) begin
                  ent_in = rd_data_ff;
               end
            end
            if (scan_ff == count_ff && !dv_ff) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = status_ff;
               rsp_in.entry_count  = 4'(count_ff);
               rsp_in.highest_code = (count_ff == '0) ? 3'd0 : best_ff.code;
               rsp_in.entry_code   = (status_ff == ST_READ_OK) ? ent_ff.code : 3'd0;
               rsp_in.entry_level  = (status_ff == ST_READ_OK) ? ent_ff.level : 8'd0;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transfer did not start the sequencer");

   a_read_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_READ_OK |-> rsp_data.entry_level != 8'd0)
      else $error("read returned an empty entry");

   a_highest_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.highest_code == 3'd0) == (count_ff == '0)))
      else $error("highest code disagrees with entry count");
`endif

endmodule
